[rtl/lpcr_pkg.sv]
// Package for the length-prefixed chunk reassembler.
// Holds the transaction payload types, configuration types and status codes.
// No dependencies.
`default_nettype none

package lpcr_pkg;

	localparam int unsigned CFG_WIDTH = 16;
	localparam int unsigned HEADER_BYTES = 4;

	localparam logic [2:0] ST_STORED  = 3'd0;
	localparam logic [2:0] ST_HEADER  = 3'd1;
	localparam logic [2:0] ST_SHORT   = 3'd2;
	localparam logic [2:0] ST_REJECT  = 3'd3;
	localparam logic [2:0] ST_OVERRUN = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;
	localparam logic [2:0] ST_STARTED = 3'd6;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_BYTE  = 1'b1;

	localparam logic CFG_CAPACITY = 1'b0;
	localparam logic CFG_MIN_LEN  = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       chunk_start;
		logic [9:0] chunk_len;
	} item_t;

	typedef struct packed {
		logic        write_valid;
		logic [14:0] write_addr;
		logic [7:0]  write_data;
		logic        complete;
		logic [15:0] received_len;
		logic [2:0]  status;
	} result_t;

	typedef struct packed {
		logic [15:0] limit;
		logic [15:0] min_len;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/length_prefixed_chunk_reassembler.sv]
// Length-prefixed chunk reassembler, top level.
// Each transaction is held in item_s1 and its result registered in rsp_q on advance.
// Throughput: one transaction per cycle while the output is not stalled by rsp_stall.
// Reset clears the reception state and loads capacity 32768 and minimum length 60.
// Depends on lpcr_pkg, lpcr_cfg_regs and lpcr_step.
`default_nettype none

module length_prefixed_chunk_reassembler #(
	parameter int unsigned BUFFER_BYTES = 32768,
	parameter int unsigned CHUNK_MAX    = 512
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  lpcr_pkg::item_t                     req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output lpcr_pkg::result_t                   rsp,
	input  wire logic                           cfg_write,
	input  wire logic                           cfg_index,
	input  wire logic [lpcr_pkg::CFG_WIDTH-1:0] cfg_wdata
);

	lpcr_pkg::cfg_t    cfg;
	lpcr_pkg::item_t   item_s1;
	lpcr_pkg::result_t result;
	lpcr_pkg::result_t rsp_q;
	logic              valid_s1;
	logic              rsp_valid_q;
	logic              advance;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	lpcr_cfg_regs #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	lpcr_step #(
		.CHUNK_MAX(CHUNK_MAX)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.item(item_s1),
		.cfg(cfg),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[rtl/lpcr_cfg_regs.sv]
// Configuration registers of the reassembler.
// Holds capacity and minimum length and derives the effective length limit.
// Depends on lpcr_pkg.
`default_nettype none

module lpcr_cfg_regs #(
	parameter int unsigned BUFFER_BYTES = 32768
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic                           cfg_index,
	input  wire logic [lpcr_pkg::CFG_WIDTH-1:0] cfg_wdata,
	output lpcr_pkg::cfg_t                      cfg
);

	logic [15:0] capacity_q;
	logic [15:0] min_len_q;
	logic [15:0] limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'd32768;
			min_len_q  <= 16'd60;
		end else if (cfg_write) begin
			case (cfg_index)
				lpcr_pkg::CFG_CAPACITY: capacity_q <= cfg_wdata;
				lpcr_pkg::CFG_MIN_LEN:  min_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The limit is the smaller of the capacity register and the buffer size.
	always_comb begin
		if (32'(capacity_q) < 32'(BUFFER_BYTES)) begin
			limit = capacity_q;
		end else begin
			limit = 16'(BUFFER_BYTES);
		end
	end

	assign cfg.limit   = limit;
	assign cfg.min_len = min_len_q;

endmodule

`default_nettype wire

[rtl/lpcr_step.sv]
// Reception state and the per-byte update of the reassembler.
// Computes one result per transaction and updates the state when advanced.
// Depends on lpcr_pkg.
`default_nettype none

module lpcr_step #(
	parameter int unsigned CHUNK_MAX = 512
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  lpcr_pkg::item_t      item,
	input  lpcr_pkg::cfg_t       cfg,
	output lpcr_pkg::result_t    result
);

	logic [15:0] declared_q, declared_n;
	logic [23:0] header_q, header_n;
	logic [15:0] stored_q, stored_n;
	logic [9:0]  offset_q, offset_n;
	logic [9:0]  cbytes_q, cbytes_n;
	logic        drop_q, drop_n;
	logic        hdr_q, hdr_n;
	logic        done_q, done_n;
	logic        have_q, have_n;
	logic [2:0]  dcode_q, dcode_n;

	always_comb begin
		logic        stray;
		logic [9:0]  off;
		logic [9:0]  clen;
		logic [9:0]  rest;
		logic [31:0] full_len;

		declared_n = declared_q;
		header_n   = header_q;
		stored_n   = stored_q;
		offset_n   = offset_q;
		cbytes_n   = cbytes_q;
		drop_n     = drop_q;
		hdr_n      = hdr_q;
		done_n     = done_q;
		have_n     = have_q;
		dcode_n    = dcode_q;
		result     = '0;
		stray      = 1'b0;
		off        = offset_q;
		clen       = item.chunk_len;
		rest       = '0;
		full_len   = '0;

		if (item.req_type == lpcr_pkg::REQ_START) begin
			declared_n = '0;
			header_n   = '0;
			stored_n   = '0;
			offset_n   = '0;
			cbytes_n   = '0;
			drop_n     = 1'b0;
			hdr_n      = 1'b0;
			done_n     = 1'b0;
			have_n     = 1'b0;
			dcode_n    = '0;
			result.status = lpcr_pkg::ST_STARTED;
		end else if (done_q) begin
			result.status = lpcr_pkg::ST_DONE;
		end else begin
			if (item.chunk_start) begin
				if (item.chunk_len == '0) begin
					clen = 10'd1;
				end
				if (32'(clen) > 32'(CHUNK_MAX)) begin
					clen = 10'(CHUNK_MAX);
				end
				cbytes_n = clen;
				off      = '0;
				drop_n   = 1'b0;
				hdr_n    = 1'b0;
				header_n = '0;
				if (!have_q) begin
					if (32'(clen) < 32'(lpcr_pkg::HEADER_BYTES)) begin
						drop_n  = 1'b1;
						dcode_n = lpcr_pkg::ST_SHORT;
					end else begin
						hdr_n = 1'b1;
					end
				end else if ({1'b0, stored_q} + {7'b0, clen} > {1'b0, declared_q}) begin
					have_n     = 1'b0;
					declared_n = '0;
					stored_n   = '0;
					drop_n     = 1'b1;
					dcode_n    = lpcr_pkg::ST_OVERRUN;
				end
			end else if (offset_q >= cbytes_q) begin
				stray = 1'b1;
			end

			if (stray) begin
				result.status = lpcr_pkg::ST_SHORT;
			end else begin
				if (drop_n) begin
					result.status = dcode_n;
				end else if (hdr_n) begin
					result.status = lpcr_pkg::ST_HEADER;
					case (off)
						10'd0: header_n[7:0]   = item.data_byte;
						10'd1: header_n[15:8]  = item.data_byte;
						10'd2: header_n[23:16] = item.data_byte;
						default: begin
							full_len = {item.data_byte, header_n};
							rest     = cbytes_n - 10'(lpcr_pkg::HEADER_BYTES);
							hdr_n    = 1'b0;
							header_n = '0;
							if (full_len < {16'b0, cfg.min_len}
									|| full_len > {16'b0, cfg.limit}) begin
								declared_n    = '0;
								drop_n        = 1'b1;
								dcode_n       = lpcr_pkg::ST_REJECT;
								result.status = lpcr_pkg::ST_REJECT;
							end else begin
								have_n     = 1'b1;
								declared_n = full_len[15:0];
								if ({1'b0, stored_n} + {7'b0, rest}
										> {1'b0, full_len[15:0]}) begin
									have_n        = 1'b0;
									declared_n    = '0;
									stored_n      = '0;
									drop_n        = 1'b1;
									dcode_n       = lpcr_pkg::ST_OVERRUN;
									result.status = lpcr_pkg::ST_OVERRUN;
								end else if (rest == '0 && stored_n == full_len[15:0]) begin
									result.complete = 1'b1;
									done_n          = 1'b1;
								end
							end
						end
					endcase
				end else begin
					result.write_valid = 1'b1;
					result.write_addr  = stored_n[14:0];
					result.write_data  = item.data_byte;
					stored_n           = stored_n + 16'd1;
					result.status      = lpcr_pkg::ST_STORED;
					if (stored_n == declared_n) begin
						result.complete = 1'b1;
						done_n          = 1'b1;
					end
				end
				offset_n = off + 10'd1;
			end
		end
		result.received_len = stored_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			declared_q <= '0;
			header_q   <= '0;
			stored_q   <= '0;
			offset_q   <= '0;
			cbytes_q   <= '0;
			drop_q     <= 1'b0;
			hdr_q      <= 1'b0;
			done_q     <= 1'b0;
			have_q     <= 1'b0;
			dcode_q    <= '0;
		end else if (advance) begin
			declared_q <= declared_n;
			header_q   <= header_n;
			stored_q   <= stored_n;
			offset_q   <= offset_n;
			cbytes_q   <= cbytes_n;
			drop_q     <= drop_n;
			hdr_q      <= hdr_n;
			done_q     <= done_n;
			have_q     <= have_n;
			dcode_q    <= dcode_n;
		end
	end

endmodule

`default_nettype wire

[tb/sv/length_prefixed_chunk_reassembler_tb.sv]
// Testbench for length_prefixed_chunk_reassembler: directed and random chunk streams, with
// stall pressure on both sides and a scoreboard that predicts and checks each result.
// Depends on lpcr_pkg and the length_prefixed_chunk_reassembler RTL.
`timescale 1ns / 1ps

class reassembly_scoreboard;
	localparam int unsigned CHUNK_LIMIT = 512;
	localparam int unsigned BUFFER_LIMIT = 32768;

	bit [15:0] capacity;
	bit [15:0] min_len;

	bit [31:0] msg_len;
	bit [23:0] len_bytes;
	bit [15:0] payload_count;
	bit [9:0] chunk_pos;
	bit [9:0] chunk_size;
	bit skip_chunk;
	bit in_header;
	bit msg_done;
	bit len_known;
	bit [2:0] skip_status;

	lpcr_pkg::result_t awaited_results[$];
	int unsigned items_noted;
	int unsigned results_checked;
	int unsigned mismatches;
	int unsigned completions;
	int unsigned settings_used;
	int unsigned status_seen[8];

	function new();
		capacity = 16'd32768;
		min_len = 16'd60;
		clear_rx();
	endfunction

	function void clear_rx();
		msg_len = '0;
		len_bytes = '0;
		payload_count = '0;
		chunk_pos = '0;
		chunk_size = '0;
		skip_chunk = 0;
		in_header = 0;
		msg_done = 0;
		len_known = 0;
		skip_status = lpcr_pkg::ST_STORED;
	endfunction

	function int unsigned size_limit();
		return (capacity < BUFFER_LIMIT) ? capacity : BUFFER_LIMIT;
	endfunction

	function void abandon_message();
		len_known = 0;
		msg_len = '0;
		payload_count = '0;
		skip_chunk = 1;
		skip_status = lpcr_pkg::ST_OVERRUN;
	endfunction

	function void write_reg(logic idx, logic [15:0] value);
		if (idx == lpcr_pkg::CFG_CAPACITY) begin
			capacity = value;
		end else begin
			min_len = value;
		end
		settings_used++;
	endfunction

	function void note_item(lpcr_pkg::item_t it);
		lpcr_pkg::result_t r;
		bit stray;
		int unsigned clen;
		int unsigned rest;
		r = '0;
		stray = 0;
		items_noted++;
		if (it.req_type == lpcr_pkg::REQ_START) begin
			clear_rx();
			r.status = lpcr_pkg::ST_STARTED;
		end else if (msg_done) begin
			r.status = lpcr_pkg::ST_DONE;
		end else begin
			if (it.chunk_start) begin
				clen = it.chunk_len;
				if (clen == 0) begin
					clen = 1;
				end
				if (clen > CHUNK_LIMIT) begin
					clen = CHUNK_LIMIT;
				end
				chunk_size = clen;
				chunk_pos = '0;
				skip_chunk = 0;
				in_header = 0;
				len_bytes = '0;
				if (!len_known) begin
					if (clen < lpcr_pkg::HEADER_BYTES) begin
						skip_chunk = 1;
						skip_status = lpcr_pkg::ST_SHORT;
					end else begin
						in_header = 1;
					end
				end else if (payload_count + clen > msg_len) begin
					abandon_message();
				end
			end else if (chunk_pos >= chunk_size) begin
				stray = 1;
			end

			if (stray) begin
				r.status = lpcr_pkg::ST_SHORT;
			end else begin
				if (skip_chunk) begin
					r.status = skip_status;
				end else if (in_header) begin
					r.status = lpcr_pkg::ST_HEADER;
					if (chunk_pos < lpcr_pkg::HEADER_BYTES - 1) begin
						len_bytes[8*chunk_pos +: 8] = it.data_byte;
					end else begin
						rest = chunk_size - lpcr_pkg::HEADER_BYTES;
						msg_len = {it.data_byte, len_bytes};
						in_header = 0;
						len_bytes = '0;
						if (msg_len < min_len || msg_len > size_limit()) begin
							msg_len = '0;
							skip_chunk = 1;
							skip_status = lpcr_pkg::ST_REJECT;
							r.status = lpcr_pkg::ST_REJECT;
						end else begin
							len_known = 1;
							if (payload_count + rest > msg_len) begin
								abandon_message();
								r.status = lpcr_pkg::ST_OVERRUN;
							end else if (rest == 0 && payload_count == msg_len) begin
								r.complete = 1;
								msg_done = 1;
							end
						end
					end
				end else begin
					r.write_valid = 1;
					r.write_addr = payload_count[14:0];
					r.write_data = it.data_byte;
					payload_count = payload_count + 16'd1;
					r.status = lpcr_pkg::ST_STORED;
					if (payload_count == msg_len) begin
						r.complete = 1;
						msg_done = 1;
					end
				end
				chunk_pos = chunk_pos + 10'd1;
			end
		end
		r.received_len = payload_count;
		status_seen[r.status]++;
		if (r.complete) begin
			completions++;
		end
		awaited_results.push_back(r);
	endfunction

	function string describe(lpcr_pkg::result_t r);
		return $sformatf("wv=%0d addr=%0d data=%02h done=%0d len=%0d status=%0d",
			r.write_valid, r.write_addr, r.write_data, r.complete, r.received_len, r.status);
	endfunction

	function void check_result(lpcr_pkg::result_t got);
		lpcr_pkg::result_t want;
		results_checked++;
		if (awaited_results.size() == 0) begin
			if (mismatches < 10) begin
				$display("ERROR %0t: result with nothing awaited: %s", $realtime, describe(got));
			end
			mismatches++;
			return;
		end
		want = awaited_results.pop_front();
		if (got.write_valid !== want.write_valid || got.write_addr !== want.write_addr ||
				got.write_data !== want.write_data || got.complete !== want.complete ||
				got.received_len !== want.received_len || got.status !== want.status) begin
			if (mismatches < 10) begin
				$display("ERROR %0t: result %0d mismatch", $realtime, results_checked);
				$display("  expected %s", describe(want));
				$display("  actual   %s", describe(got));
			end
			mismatches++;
		end
	endfunction

	function bit calm();
		return items_noted >= 1000 && items_noted < 1250;
	endfunction
endclass

module length_prefixed_chunk_reassembler_tb;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 400;

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	lpcr_pkg::item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	lpcr_pkg::result_t rsp;
	logic cfg_write = 0;
	logic cfg_index = lpcr_pkg::CFG_CAPACITY;
	logic [lpcr_pkg::CFG_WIDTH-1:0] cfg_wdata = '0;

	reassembly_scoreboard sb = new();
	int unsigned cycles = 0;

	length_prefixed_chunk_reassembler #(
		.BUFFER_BYTES(32768),
		.CHUNK_MAX(512)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_result(rsp);
		end
	end

	initial begin
		int unsigned hold;
		bit held;
		hold = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sb.items_noted >= 520) begin
				held = 1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				rsp_stall <= 1;
			end else begin
				rsp_stall <= !sb.calm() && ($urandom_range(99) < 12);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("length_prefixed_chunk_reassembler verification failed");
		$finish;
	end

	task automatic drive(lpcr_pkg::item_t it);
		while (!sb.calm() && $urandom_range(99) < 12) begin
			req_valid <= 0;
			@(negedge clk);
		end
		req_valid <= 1;
		req <= it;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic send_byte(bit first, logic [9:0] field, logic [7:0] value);
		lpcr_pkg::item_t it;
		it.req_type = lpcr_pkg::REQ_BYTE;
		it.data_byte = value;
		it.chunk_start = first;
		it.chunk_len = first ? field : 10'($urandom);
		drive(it);
	endtask

	task automatic send_start();
		lpcr_pkg::item_t it;
		it = lpcr_pkg::item_t'($urandom);
		it.req_type = lpcr_pkg::REQ_START;
		drive(it);
	endtask

	task automatic send_stray();
		send_byte(0, '0, 8'($urandom));
	endtask

	task automatic send_noise();
		lpcr_pkg::item_t it;
		it = lpcr_pkg::item_t'($urandom);
		it.req_type = ($urandom_range(15) == 0) ? lpcr_pkg::REQ_START : lpcr_pkg::REQ_BYTE;
		drive(it);
	endtask

	// Sends k of the n bytes of a chunk; a header chunk opens with the length word.
	task automatic send_chunk(int unsigned n, int unsigned k, bit hdr, logic [31:0] len);
		logic [9:0] field;
		logic [7:0] value;
		int unsigned i;
		field = n;
		if (n == 1 && $urandom_range(1)) begin
			field = '0;
		end
		if (n == 512 && $urandom_range(1)) begin
			field = $urandom_range(1023, 512);
		end
		for (i = 0; i < k; i++) begin
			value = (hdr && i < 4) ? len[8*i +: 8] : 8'($urandom);
			send_byte(i == 0, field, value);
		end
	endtask

	task automatic settle();
		req_valid <= 0;
		while (sb.awaited_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_write <= 0;
		sb.write_reg(idx, value);
	endtask

	task automatic set_config(logic [15:0] cap, logic [15:0] lo);
		settle();
		write_reg(lpcr_pkg::CFG_CAPACITY, cap);
		write_reg(lpcr_pkg::CFG_MIN_LEN, lo);
	endtask

	function automatic bit lengths_possible();
		return sb.min_len <= sb.size_limit();
	endfunction

	function automatic int unsigned pick_len();
		int unsigned lo;
		int unsigned hi;
		lo = sb.min_len;
		hi = sb.size_limit();
		if ($urandom_range(9) == 0) begin
			return ($urandom_range(1) || hi > 800) ? lo : hi;
		end
		if (hi - lo > 160) begin
			return lo + $urandom_range(160);
		end
		return $urandom_range(hi, lo);
	endfunction

	function automatic logic [31:0] pick_bad_len();
		logic [31:0] v;
		if (sb.min_len > 0 && $urandom_range(1)) begin
			return $urandom_range(sb.min_len - 1, 0);
		end
		if ($urandom_range(1)) begin
			return sb.size_limit() + 1 + $urandom_range(2000);
		end
		v = $urandom;
		v[31] = 1'b1;
		return v;
	endfunction

	task automatic run_message(bit with_start);
		int unsigned total;
		int unsigned first;
		int unsigned rem;
		int unsigned n;
		int unsigned k;
		bit whole;
		total = pick_len();
		if (with_start) begin
			send_start();
		end
		first = $urandom_range(total < 508 ? total : 508, 0);
		send_chunk(4 + first, 4 + first, 1, total);
		rem = total - first;
		whole = 1;
		while (rem > 0) begin
			if (whole && $urandom_range(19) == 0) begin
				send_stray();
			end
			n = $urandom_range(rem < 48 ? rem : 48, 1);
			k = n;
			if ($urandom_range(19) == 0) begin
				k = $urandom_range(n, 1);
			end
			whole = (k == n);
			send_chunk(n, k, 0, '0);
			rem -= k;
		end
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(3, 1)) send_stray();
		end
	endtask

	task automatic overrun_op();
		int unsigned total;
		int unsigned first;
		int unsigned n;
		total = pick_len();
		send_start();
		if (total == 0 || total > 500 || $urandom_range(2) == 0) begin
			first = total + 1 + $urandom_range(7);
			if (first > 508) begin
				first = 508;
			end
			send_chunk(4 + first, 4 + first, 1, total);
		end else begin
			first = $urandom_range(total - 1, 0);
			send_chunk(4 + first, 4 + first, 1, total);
			n = total - first + 1 + $urandom_range(7);
			if (n > 512) begin
				n = 512;
			end
			send_chunk(n, n, 0, '0);
		end
		if ($urandom_range(1)) begin
			run_message(0);
		end
	endtask

	task automatic big_chunk_op();
		int unsigned total;
		total = 508 + $urandom_range(50);
		send_start();
		send_chunk(512, 512, 1, total);
		send_stray();
		send_stray();
		if (total > 508) begin
			send_chunk(total - 508, total - 508, 0, '0);
		end
	endtask

	task automatic random_op();
		int unsigned pick;
		int unsigned n;
		bit ok;
		pick = $urandom_range(99);
		ok = lengths_possible();
		if (pick < 65 && ok) begin
			run_message($urandom_range(9) != 0);
		end else if (pick < 72) begin
			if ($urandom_range(4) != 0) begin
				send_start();
			end
			n = 4 + $urandom_range(6);
			send_chunk(n, n, 1, pick_bad_len());
			if (ok && $urandom_range(1)) begin
				run_message(0);
			end
		end else if (pick < 80 && ok) begin
			overrun_op();
		end else if (pick < 86) begin
			if ($urandom_range(9) < 7) begin
				send_start();
			end
			n = $urandom_range(3, 1);
			send_chunk(n, n, 0, '0);
			if (ok && $urandom_range(1)) begin
				run_message(0);
			end
		end else if (pick < 90 && ok) begin
			send_start();
			send_chunk(4 + $urandom_range(20), $urandom_range(3, 1), 1, pick_len());
			run_message(0);
		end else if (pick >= 97 && ok && sb.size_limit() >= 558 && sb.min_len <= 508) begin
			big_chunk_op();
		end else begin
			repeat ($urandom_range(6, 1)) send_noise();
		end
	endtask

	task automatic run_phase(logic [15:0] cap, logic [15:0] lo, int unsigned count);
		int unsigned target;
		set_config(cap, lo);
		target = sb.items_noted + count;
		while (sb.items_noted < target) begin
			random_op();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_start();
		send_stray();
		send_chunk(3, 3, 0, '0);
		send_byte(1, 10'd0, 8'hFF);
		send_chunk(4, 4, 1, 32'd59);
		send_chunk(5, 5, 1, 32'hFFFF_FFFF);

		set_config(16'd0, 16'd0);
		send_start();
		send_chunk(4, 4, 1, 32'd0);
		send_byte(1, 10'd3, 8'h00);
		send_start();
		send_chunk(6, 6, 1, 32'd1);

		set_config(16'hFFFF, 16'h8000);
		send_start();
		send_chunk(4, 4, 1, 32'h0000_8000);
		send_chunk(4, 4, 1, 32'h0000_8001);

		run_phase(16'd32768, 16'd60, 300);
		run_phase(16'd0, 16'd0, 300);
		run_phase(16'd120, 16'd0, 300);
		run_phase(16'd80, 16'd80, 300);
		run_phase(16'd700, 16'd16, 300);
		run_phase(16'd32768, 16'd4, 300);

		settle();
		repeat (10) @(posedge clk);
		$display("Run: %0d transactions sent, %0d results checked, %0d messages completed,",
			sb.items_noted, sb.results_checked, sb.completions);
		$display("  %0d register writes; outcomes: stored %0d, header %0d, short or stray %0d,",
			sb.settings_used, sb.status_seen[lpcr_pkg::ST_STORED],
			sb.status_seen[lpcr_pkg::ST_HEADER], sb.status_seen[lpcr_pkg::ST_SHORT]);
		$display("  rejected %0d, overrun %0d, ignored %0d, started %0d.",
			sb.status_seen[lpcr_pkg::ST_REJECT], sb.status_seen[lpcr_pkg::ST_OVERRUN],
			sb.status_seen[lpcr_pkg::ST_DONE], sb.status_seen[lpcr_pkg::ST_STARTED]);
		if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
			$display("length_prefixed_chunk_reassembler verification clean");
		end else begin
			$display("length_prefixed_chunk_reassembler verification failed");
		end
		$finish;
	end
endmodule

[files.f]
rtl/lpcr_pkg.sv
rtl/lpcr_cfg_regs.sv
rtl/lpcr_step.sv
rtl/length_prefixed_chunk_reassembler.sv
tb/sv/length_prefixed_chunk_reassembler_tb.sv
